>>> rtl/hbs_pkg.sv
// Shared types and constants for the 3x3 height map smoother.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package hbs_pkg;

  // Field and register widths.
  localparam int SAMPLE_BITS   = 16;
  localparam int ROW_BITS      = 13;
  localparam int COL_BITS      = 11;
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_IDX_BITS  = 1;
  localparam int TOTAL_BITS    = ROW_BITS + COL_BITS;
  // The emitted count runs up to the largest map size.
  localparam int EMIT_BITS     = TOTAL_BITS;

  // Register limits and reset value.
  localparam int ROW_MAX    = 4096;
  localparam int MIN_SIZE   = 2;
  localparam int SIZE_RESET = 513;

  // Window and queue sizes.
  localparam int WIN_CELLS   = 9;
  localparam int QUEUE_DEPTH = 4;

  // Window sum width: nine samples need four more bits.
  localparam int SUM_BITS = SAMPLE_BITS + 4;

  // Reciprocals for the floor division, scaled by two to the RECIP_SHIFT.
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_BITS  = RECIP_SHIFT + 1;
  localparam logic [RECIP_BITS-1:0] RECIP_ONE   = RECIP_BITS'(2 ** RECIP_SHIFT);
  localparam logic [RECIP_BITS-1:0] RECIP_THIRD = RECIP_BITS'((2 ** RECIP_SHIFT + 2) / 3);
  localparam logic [RECIP_BITS-1:0] RECIP_NINTH = RECIP_BITS'((2 ** RECIP_SHIFT + 8) / 9);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cfg_reg_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WIN_CELLS-1:0][SAMPLE_BITS-1:0] window_t;

  // Which sides of the centre cell fall outside the raster.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  // One emitting position, as passed from the front end to the back end.
  typedef struct packed {
    window_t cells;
    border_t border;
    logic    last;
  } job_t;

  typedef struct packed {
    op_e     op;
    sample_t height;
  } in_word_t;

  typedef struct packed {
    sample_t smoothed;
    logic    frame_last;
  } out_word_t;

endpackage

`default_nettype wire

>>> rtl/hbs_front.sv
// Front end of the smoother: configuration registers, scan position, line stores
// and the 3x3 window. Classifies each word and pushes emitting positions on.
// Depends on hbs_pkg.
`default_nettype none

module hbs_front #(
  parameter int MAX_COLS = 1024
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [hbs_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  wire  [hbs_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  input  wire                                   push_i,
  input  hbs_pkg::in_word_t                     in_i,
  output logic                                  full_o,
  input  wire                                   q_afull_i,
  output logic                                  q_push_o,
  output hbs_pkg::job_t                         q_job_o
);

  localparam int AW     = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int RW     = hbs_pkg::ROW_BITS;
  localparam int CW     = hbs_pkg::COL_BITS;
  localparam int TW     = hbs_pkg::TOTAL_BITS;
  localparam int EW     = hbs_pkg::EMIT_BITS;
  localparam int SB     = hbs_pkg::SAMPLE_BITS;
  localparam int COL_HI = (MAX_COLS > (2 ** CW - 1)) ? (2 ** CW - 1) : MAX_COLS;
  localparam int COL_RST = (hbs_pkg::SIZE_RESET > COL_HI) ? COL_HI : hbs_pkg::SIZE_RESET;
  localparam int PW     = ((AW > CW) ? AW : CW) + 1;
  localparam logic [TW-1:0] TOTAL_RST = TW'(hbs_pkg::SIZE_RESET * COL_RST);

  // Configuration and scan state.
  logic [RW-1:0] rows_q, rows_d;
  logic [CW-1:0] cols_q, cols_d;
  logic [TW-1:0] total_q;
  logic [RW-1:0] scan_row_q, scan_row_d;
  logic [AW-1:0] scan_col_q, scan_col_d;
  logic [EW-1:0] emitted_q, emitted_d;
  logic          cfg_hit;

  // Stage one: the accepted word waiting for its line store data.
  logic                    f1_valid_q;
  logic                    f1_emit_q;
  logic                    f1_last_q;
  hbs_pkg::border_t        f1_border_q;
  logic [SB-1:0]           f1_cur_q;
  logic [AW-1:0]           f1_addr_q;
  logic [SB-1:0]           rd_up_q;
  logic [SB-1:0]           rd_mid_q;

  // Line stores: the two rows above the current one.
  logic [SB-1:0] upper_mem  [MAX_COLS];
  logic [SB-1:0] middle_mem [MAX_COLS];

  hbs_pkg::window_t win_q, win_d;

  logic             accept;
  logic             c_nz;
  logic [PW-1:0]    c_ext;
  logic             col_wrap;
  logic             emit;
  logic             last;
  hbs_pkg::border_t border;
  logic [SB-1:0]    cur;
  logic [RW-1:0]    row_raw;
  logic [CW-1:0]    col_raw;

  assign accept = push_i && !full_o;
  assign full_o = q_afull_i;
  assign cur    = (in_i.op == hbs_pkg::OP_FLUSH) ? '0 : in_i.height;

  // Register writes, clamped to the supported range.
  always_comb begin
    row_raw = cfg_data_i[RW-1:0];
    col_raw = cfg_data_i[CW-1:0];
    rows_d  = rows_q;
    cols_d  = cols_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      if (cfg_idx_i == hbs_pkg::REG_ROW_COUNT) begin
        cfg_hit = 1'b1;
        if (row_raw < RW'(hbs_pkg::MIN_SIZE)) begin
          rows_d = RW'(hbs_pkg::MIN_SIZE);
        end else if (row_raw > RW'(hbs_pkg::ROW_MAX)) begin
          rows_d = RW'(hbs_pkg::ROW_MAX);
        end else begin
          rows_d = row_raw;
        end
      end else if (cfg_idx_i == hbs_pkg::REG_COL_COUNT) begin
        cfg_hit = 1'b1;
        if (col_raw < CW'(hbs_pkg::MIN_SIZE)) begin
          cols_d = CW'(hbs_pkg::MIN_SIZE);
        end else if (col_raw > CW'(COL_HI)) begin
          cols_d = CW'(COL_HI);
        end else begin
          cols_d = col_raw;
        end
      end
    end
  end

  // Classify the position of the incoming word. The centre cell lies one row
  // and one column back, or two rows back at the last column when col is zero.
  always_comb begin
    c_nz          = scan_col_q != '0;
    c_ext         = PW'(scan_col_q);
    col_wrap      = (c_ext + PW'(1)) >= PW'(cols_q);
    emit          = (scan_row_q >= RW'(2)) || ((scan_row_q == RW'(1)) && c_nz);
    border.top    = c_nz ? (scan_row_q == RW'(1)) : (scan_row_q == RW'(2));
    border.bottom = c_nz ? (scan_row_q >= rows_q) : (scan_row_q > rows_q);
    border.left   = c_ext == PW'(1);
    border.right  = !c_nz;
    last          = emit && ((TW'(emitted_q) + TW'(1)) >= total_q);
  end

  // Next scan position; a register write or the end of a map restarts the frame.
  always_comb begin
    scan_row_d = scan_row_q;
    scan_col_d = scan_col_q;
    emitted_d  = emitted_q;
    if (cfg_hit) begin
      scan_row_d = '0;
      scan_col_d = '0;
      emitted_d  = '0;
    end else if (accept) begin
      if (last) begin
        scan_row_d = '0;
        scan_col_d = '0;
        emitted_d  = '0;
      end else begin
        if (col_wrap) begin
          scan_col_d = '0;
          scan_row_d = scan_row_q + RW'(1);
        end else begin
          scan_col_d = scan_col_q + AW'(1);
        end
        if (emit) begin
          emitted_d = emitted_q + EW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= RW'(hbs_pkg::SIZE_RESET);
      cols_q     <= CW'(COL_RST);
      total_q    <= TOTAL_RST;
      scan_row_q <= '0;
      scan_col_q <= '0;
      emitted_q  <= '0;
      f1_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      rows_q     <= rows_d;
      cols_q     <= cols_d;
      total_q    <= TW'(rows_q) * TW'(cols_q);
      scan_row_q <= scan_row_d;
      scan_col_q <= scan_col_d;
      emitted_q  <= emitted_d;
      f1_valid_q <= accept;
      win_q      <= win_d;
    end
  end

  // Payload of stage one.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_emit_q   <= emit;
      f1_last_q   <= last;
      f1_border_q <= border;
      f1_cur_q    <= cur;
      f1_addr_q   <= scan_col_q;
    end
  end

  // Line stores: read on accept, written back from stage one. The upper row
  // takes the old middle entry and the middle row takes the new sample.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_up_q  <= upper_mem[scan_col_q];
      rd_mid_q <= middle_mem[scan_col_q];
    end
    if (f1_valid_q) begin
      upper_mem[f1_addr_q]  <= rd_mid_q;
      middle_mem[f1_addr_q] <= f1_cur_q;
    end
  end

  // Shift the window by one column and bring in the new right-hand column.
  always_comb begin
    win_d = win_q;
    if (f1_valid_q) begin
      for (int k = 0; k < 3; k++) begin
        win_d[3 * k]     = win_q[3 * k + 1];
        win_d[3 * k + 1] = win_q[3 * k + 2];
      end
      win_d[2] = rd_up_q;
      win_d[5] = rd_mid_q;
      win_d[8] = f1_cur_q;
    end
  end

  assign q_push_o      = f1_valid_q && f1_emit_q;
  assign q_job_o.cells  = win_d;
  assign q_job_o.border = f1_border_q;
  assign q_job_o.last   = f1_last_q;

  // The word after the final cell of a map starts again at the origin.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> ((scan_row_q == '0) && (scan_col_q == '0) && (emitted_q == '0)))
    else $error("scan position not cleared after the final cell");

  // A job is only handed on in the cycle after its word was accepted.
  a_push_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> $past(accept))
    else $error("job pushed without an accepted word");

endmodule

`default_nettype wire

>>> rtl/hbs_queue.sv
// Short queue of window jobs between the front and the back end.
// Depends on hbs_pkg.
`default_nettype none

module hbs_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  hbs_pkg::job_t  job_i,
  input  wire            pop_i,
  output hbs_pkg::job_t  head_o,
  output logic           empty_o,
  output logic           afull_o
);

  localparam int DEPTH = hbs_pkg::QUEUE_DEPTH;
  localparam int PTRW  = $clog2(DEPTH);
  localparam int CNTW  = PTRW + 1;

  hbs_pkg::job_t   slots_q [DEPTH];
  logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] count_q;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTRW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTRW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNTW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNTW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

  assign head_o  = slots_q[rd_ptr_q];
  assign empty_o = count_q == '0;
  // One place is kept for the job still in the front end's stage one.
  assign afull_o = count_q >= CNTW'(DEPTH - 1);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < CNTW'(DEPTH)))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("job queue underflow");

endmodule

`default_nettype wire

>>> rtl/hbs_back.sv
// Back end of the smoother: sums the cells inside the raster, divides by the
// cell count with a reciprocal multiply and holds the result word. Uses hbs_pkg.
`default_nettype none

module hbs_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_empty_i,
  input  hbs_pkg::job_t       q_job_i,
  output logic                q_pop_o,
  input  wire                 pop_i,
  output logic                empty_o,
  output hbs_pkg::out_word_t  out_o
);

  localparam int SB    = hbs_pkg::SAMPLE_BITS;
  localparam int SUMW  = hbs_pkg::SUM_BITS;
  localparam int MW    = hbs_pkg::RECIP_BITS;
  localparam int PRODW = SUMW + MW;
  localparam logic signed [SUMW-1:0] OFF_ONE   = SUMW'(2 ** (SB - 1));
  localparam logic signed [SUMW-1:0] OFF_THREE = SUMW'(3 * 2 ** (SB - 1));
  localparam logic signed [SUMW-1:0] OFF_NINE  = SUMW'(9 * 2 ** (SB - 1));
  localparam logic [SB-1:0]          HALF      = SB'(2 ** (SB - 1));

  typedef enum logic [1:0] {
    DIV_FOUR,
    DIV_SIX,
    DIV_NINE
  } div_e;

  logic en;

  // Stage one: masked sum and divisor class.
  logic                   s1_valid_q;
  logic signed [SUMW-1:0] s1_sum_q, sum;
  div_e                   s1_div_q, div;
  logic                   s1_last_q;
  logic [2:0]             row_ok, col_ok;

  // Stage two: reciprocal product.
  logic                   s2_valid_q;
  logic [PRODW-1:0]       s2_prod_q, prod;
  logic                   s2_last_q;
  logic signed [SUMW-1:0] scaled, offset;
  logic [SUMW-1:0]        biased;
  logic [MW-1:0]          recip;

  // Output word.
  logic                   out_valid_q;
  hbs_pkg::out_word_t     out_q;
  logic [SB-1:0]          quot;

  // The whole pipe moves unless a finished word is waiting to be taken.
  assign en      = !out_valid_q || pop_i;
  assign q_pop_o = en && !q_empty_i;

  // Sum the cells that lie inside the raster.
  always_comb begin
    row_ok = {!q_job_i.border.bottom, 1'b1, !q_job_i.border.top};
    col_ok = {!q_job_i.border.right, 1'b1, !q_job_i.border.left};
    sum    = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          sum = sum + SUMW'($signed(q_job_i.cells[3 * r + c]));
        end
      end
    end
    if (row_ok[0] && row_ok[2] && col_ok[0] && col_ok[2]) begin
      div = DIV_NINE;
    end else if ((!row_ok[0] || !row_ok[2]) && (!col_ok[0] || !col_ok[2])) begin
      div = DIV_FOUR;
    end else begin
      div = DIV_SIX;
    end
  end

  // Floor division: pre-shift for the powers of two, bias to non-negative,
  // then multiply by the rounded-up reciprocal of three or nine.
  always_comb begin
    unique case (s1_div_q)
      DIV_FOUR: begin
        scaled = s1_sum_q >>> 2;
        offset = OFF_ONE;
        recip  = hbs_pkg::RECIP_ONE;
      end
      DIV_SIX: begin
        scaled = s1_sum_q >>> 1;
        offset = OFF_THREE;
        recip  = hbs_pkg::RECIP_THIRD;
      end
      DIV_NINE: begin
        scaled = s1_sum_q;
        offset = OFF_NINE;
        recip  = hbs_pkg::RECIP_NINTH;
      end
      default: begin
        scaled = s1_sum_q;
        offset = OFF_NINE;
        recip  = hbs_pkg::RECIP_NINTH;
      end
    endcase
    biased = unsigned'(scaled + offset);
    prod   = PRODW'(biased) * PRODW'(recip);
  end

  // Take the biased quotient from the product; the bias is removed in the output word.
  assign quot = s2_prod_q[hbs_pkg::RECIP_SHIFT +: SB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= q_pop_o;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sum_q             <= sum;
      s1_div_q             <= div;
      s1_last_q            <= q_job_i.last;
      s2_prod_q            <= prod;
      s2_last_q            <= s1_last_q;
      out_q.smoothed       <= hbs_pkg::sample_t'(quot - HALF);
      out_q.frame_last     <= s2_last_q;
    end
  end

  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

  // A product in the last stage reaches the output word when the pipe moves.
  a_pipe_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s2_valid_q) |=> out_valid_q)
    else $error("result word lost between product and output");

endmodule

`default_nettype wire

>>> rtl/heightmap_box_smoother_3x3.sv
// 3x3 box smoother for a row-major raster of signed Q8.8 heights.
//
// Input channel: push/full with word in_i (op, height). A map is row_count
// times col_count samples followed by col_count+1 flush words. Each word from
// raster position col_count+1 on gives one result word on out_o: the floored
// mean of the cell col_count+1 positions back and its neighbours inside the
// raster; frame_last marks the final cell, after which a new map begins.
// Result channel: empty/pop; the oldest word is shown while empty is low.
// Throughput is one word per cycle while full stays low. A result word passes
// the line store read, the job queue, the window sum and the reciprocal
// multiply before it is held as the output word; the line store read/write-back
// pair sets the one-word-per-cycle pace. Configuration writes (cfg_we_i,
// cfg_idx_i, cfg_data_i) take effect at once and restart the map; the user must
// make them only while the block is idle, which the block does not enforce.
// Reset clears the scan position and the pipeline and sets the row count to 513
// and the column count to 513, or to MAX_COLS if smaller; the line stores need no
// clearing. When pop stays low the result word holds, the back end stops, full
// rises once three of the job queue's four entries are taken, and the queue fills.
// Depends on hbs_pkg, hbs_front, hbs_queue and hbs_back.
`default_nettype none

module heightmap_box_smoother_3x3 #(
  parameter int MAX_COLS = 1024
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [hbs_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire  [hbs_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  wire                                push,
  input  hbs_pkg::in_word_t                  in_i,
  output logic                               full,
  output logic                               empty,
  input  wire                                pop,
  output hbs_pkg::out_word_t                 out_o
);

  logic          q_push;
  hbs_pkg::job_t q_job_in;
  hbs_pkg::job_t q_head;
  logic          q_pop;
  logic          q_empty;
  logic          q_afull;

  // Front end: scan position, line stores and window.
  hbs_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .in_i       (in_i),
    .full_o     (full),
    .q_afull_i  (q_afull),
    .q_push_o   (q_push),
    .q_job_o    (q_job_in)
  );

  // Job queue between the two halves.
  hbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty),
    .afull_o (q_afull)
  );

  // Back end: sum, divide and result word.
  hbs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_job_i   (q_head),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

>>> bench/hbs_smooth_checker.sv
`timescale 1ns / 100ps
// Checker for the 3x3 height map smoother: watches the register port and both
// word channels, predicts every result word and compares it with the block.
// Depends on hbs_pkg for the word types, register indexes and size limits.

module hbs_smooth_checker #(
  parameter int MAX_COLS = 1024
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [hbs_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire  [hbs_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  wire                                push_i,
  input  wire                                full_i,
  input  hbs_pkg::in_word_t                  in_i,
  input  wire                                pop_i,
  input  wire                                empty_i,
  input  hbs_pkg::out_word_t                 out_i,
  output int                                 pending_o,
  output int                                 fail_count_o
);

  // Own copy of the line stores, the window and the scan position.
  hbs_pkg::sample_t   upper_row [MAX_COLS];
  hbs_pkg::sample_t   middle_row [MAX_COLS];
  hbs_pkg::sample_t   win [hbs_pkg::WIN_CELLS];
  int                 row_pos;
  int                 col_pos;
  int                 emitted;
  int                 rows;
  int                 cols;
  int                 mismatches;
  hbs_pkg::out_word_t due_words [$];

  function automatic int clamp_size(input int v, input int hi);
    if (v < hbs_pkg::MIN_SIZE) return hbs_pkg::MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic restart_map();
    row_pos = 0;
    col_pos = 0;
    emitted = 0;
    for (int i = 0; i < hbs_pkg::WIN_CELLS; i++) win[i] = '0;
  endtask

  // Advances the scan by one word and queues the smoothed height it releases.
  task automatic smooth_step(input hbs_pkg::in_word_t w);
    int                 r;
    int                 c;
    int                 qr;
    int                 qc;
    int                 sum;
    int                 cnt;
    int                 mean;
    bit                 row_ok;
    bit                 col_ok;
    hbs_pkg::sample_t   cur;
    hbs_pkg::out_word_t due;
    r   = row_pos;
    c   = col_pos;
    cur = (w.op == hbs_pkg::OP_FLUSH) ? hbs_pkg::sample_t'(0) : w.height;
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = upper_row[c];
    win[5] = middle_row[c];
    win[8] = cur;
    upper_row[c]  = win[5];
    middle_row[c] = cur;

    if (c >= 1) begin
      qr = r - 1;
      qc = c - 1;
    end else begin
      qr = r - 2;
      qc = cols - 1;
    end
    if (c + 1 >= cols) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    // Nothing leaves until the window centre has a full row behind it.
    if (!(r >= 2 || (r == 1 && c >= 1))) return;

    // Only cells inside the raster count towards the mean.
    sum = 0;
    cnt = 0;
    for (int k = 0; k < 3; k++) begin
      row_ok = (k == 0) ? (qr >= 1) : (k == 1) ? 1'b1 : (qr + 1 < rows);
      for (int j = 0; j < 3; j++) begin
        col_ok = (j == 0) ? (qc >= 1) : (j == 1) ? 1'b1 : (qc + 1 < cols);
        if (row_ok && col_ok) begin
          sum += int'(win[k*3+j]);
          cnt++;
        end
      end
    end
    // Integer division truncates, so negative sums need one step down.
    mean = sum / cnt;
    if ((sum % cnt) != 0 && sum < 0) mean--;

    due.smoothed   = hbs_pkg::sample_t'(mean);
    due.frame_last = (emitted + 1 >= rows * cols);
    due_words.push_back(due);
    if (due.frame_last) restart_map();
    else emitted++;
  endtask

  task automatic compare_word(input hbs_pkg::out_word_t got);
    hbs_pkg::out_word_t want;
    bit                 bad;
    if (due_words.size() == 0) begin
      $display("%0t: unexpected result word, expected none, actual smoothed=%0d frame_last=%0b",
               $time, got.smoothed, got.frame_last);
      mismatches++;
      return;
    end
    want = due_words.pop_front();
    bad  = 1'b0;
    if (got.smoothed !== want.smoothed) begin
      $display("%0t: smoothed expected %0d, actual %0d",
               $time, want.smoothed, got.smoothed);
      bad = 1'b1;
    end
    if (got.frame_last !== want.frame_last) begin
      $display("%0t: frame_last expected %0b, actual %0b",
               $time, want.frame_last, got.frame_last);
      bad = 1'b1;
    end
    if (bad) mismatches++;
  endtask

  // Everything is sampled at the rising edge, before the block's outputs move.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows       = hbs_pkg::SIZE_RESET;
      cols       = hbs_pkg::SIZE_RESET;
      mismatches = 0;
      restart_map();
      due_words.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (pop_i && !empty_i) compare_word(out_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hbs_pkg::REG_ROW_COUNT:
            rows = clamp_size(int'(cfg_data_i), hbs_pkg::ROW_MAX);
          hbs_pkg::REG_COL_COUNT:
            cols = clamp_size(int'(cfg_data_i[hbs_pkg::COL_BITS-1:0]), MAX_COLS);
          default: ;
        endcase
        restart_map();
      end
      if (push_i && !full_i) smooth_step(in_i);
      pending_o    <= due_words.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

>>> bench/heightmap_box_smoother_3x3_tb.sv
`timescale 1ns / 100ps
// Testbench top for the 3x3 height map smoother: clock, reset, register
// writes, height words and pop pacing. Depends on hbs_pkg and the checker.

module heightmap_box_smoother_3x3_tb;

  localparam int MAX_COLS      = 1024;
  localparam int RANDOM_WORDS  = 1030;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  hbs_pkg::cfg_reg_e                 cfg_idx = hbs_pkg::REG_ROW_COUNT;
  logic [hbs_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                              push = 1'b0;
  hbs_pkg::in_word_t                 in_word = '0;
  logic                              full;
  logic                              empty;
  logic                              pop = 1'b0;
  hbs_pkg::out_word_t                out_word;
  int                                pending;
  int                                fail_count;

  int send_idle = 11;
  int recv_idle = 60;
  int words_sent = 0;
  int stall_cycles = 0;
  int cur_rows = hbs_pkg::SIZE_RESET;
  int cur_cols = hbs_pkg::SIZE_RESET;

  heightmap_box_smoother_3x3 #(.MAX_COLS(MAX_COLS)) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .push       (push),
    .in_i       (in_word),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_word)
  );

  hbs_smooth_checker #(.MAX_COLS(MAX_COLS)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .push_i       (push),
    .full_i       (full),
    .in_i         (in_word),
    .pop_i        (pop),
    .empty_i      (empty),
    .out_i        (out_word),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #5 clk = ~clk;

  // The receiver holds pop low with a chance of recv_idle in a hundred.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle);
  end

  // Ends the run when no word moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || cfg_we) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic int clamp_size(input int v, input int hi);
    if (v < hbs_pkg::MIN_SIZE) return hbs_pkg::MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // Offers one word and returns at the edge where it is taken.
  task automatic send_word(input hbs_pkg::op_e op, input hbs_pkg::sample_t height);
    hbs_pkg::in_word_t w;
    w.op     = op;
    w.height = height;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
  endtask

  // Registers change only once every result is out and the pipe has settled.
  task automatic write_reg(input hbs_pkg::cfg_reg_e idx,
                           input logic [hbs_pkg::CFG_DATA_BITS-1:0] data);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hbs_pkg::REG_ROW_COUNT) begin
      cur_rows = clamp_size(int'(data), hbs_pkg::ROW_MAX);
    end else begin
      cur_cols = clamp_size(int'(data[hbs_pkg::COL_BITS-1:0]), MAX_COLS);
    end
  endtask

  initial begin
    int                                start;
    int                                len;
    int                                total;
    int                                pixels;
    bit                                restart_due;
    bit                                extremes;
    bit                                do_rows;
    bit                                do_cols;
    logic [hbs_pkg::CFG_DATA_BITS-1:0] row_data;
    logic [hbs_pkg::CFG_DATA_BITS-1:0] col_data;
    hbs_pkg::op_e                      op;
    hbs_pkg::sample_t                  h;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: 2x2 maps with register values below the minimum.
    write_reg(hbs_pkg::REG_ROW_COUNT, 13'd0);
    write_reg(hbs_pkg::REG_COL_COUNT, 13'd1);
    repeat (4) send_word(hbs_pkg::OP_SAMPLE, 16'sh7fff);
    repeat (3) send_word(hbs_pkg::OP_FLUSH, 16'sh0000);
    repeat (4) send_word(hbs_pkg::OP_SAMPLE, 16'sh8000);
    repeat (3) send_word(hbs_pkg::OP_FLUSH, 16'sh7fff);
    // A flush among the samples counts as zero; the mean of -1 floors to -1.
    send_word(hbs_pkg::OP_SAMPLE, -16'sd1);
    send_word(hbs_pkg::OP_SAMPLE, 16'sh0000);
    send_word(hbs_pkg::OP_FLUSH, 16'sh8000);
    send_word(hbs_pkg::OP_SAMPLE, 16'sh0000);
    // A sample in the flush phase is only a flush tick.
    send_word(hbs_pkg::OP_SAMPLE, 16'sd12345);
    repeat (2) send_word(hbs_pkg::OP_FLUSH, 16'sh5555);
    // Half a map, cut short by the next register write.
    send_word(hbs_pkg::OP_SAMPLE, 16'sd1);
    send_word(hbs_pkg::OP_SAMPLE, 16'sh7fff);

    // Largest sizes: both registers above their limits, then the tallest map.
    write_reg(hbs_pkg::REG_ROW_COUNT, 13'h1fff);
    write_reg(hbs_pkg::REG_COL_COUNT, 13'h07ff);
    repeat (24) send_word(hbs_pkg::OP_SAMPLE, hbs_pkg::sample_t'($urandom));
    write_reg(hbs_pkg::REG_ROW_COUNT, 13'd4096);
    write_reg(hbs_pkg::REG_COL_COUNT, 13'd3);
    repeat (20) send_word(hbs_pkg::OP_SAMPLE, hbs_pkg::sample_t'($urandom));
    write_reg(hbs_pkg::REG_COL_COUNT, 13'd1024);
    repeat (8) send_word(hbs_pkg::OP_SAMPLE, hbs_pkg::sample_t'($urandom));

    // Random part: small maps, some cut short, with a little noise.
    start       = words_sent;
    restart_due = 1'b1;
    while (words_sent - start < RANDOM_WORDS) begin
      if (restart_due || $urandom_range(1)) begin
        row_data = 13'($urandom_range(2, 6));
        col_data = 13'($urandom_range(2, 9));
        if ($urandom_range(9) == 0) row_data = 13'($urandom_range(1));
        if ($urandom_range(9) == 0) col_data = 13'($urandom_range(1));
        if ($urandom_range(9) == 0) col_data = col_data | 13'h0800;
        do_rows = restart_due | $urandom_range(1);
        do_cols = restart_due | $urandom_range(1) | !do_rows;
        if (do_rows) write_reg(hbs_pkg::REG_ROW_COUNT, row_data);
        if (do_cols) write_reg(hbs_pkg::REG_COL_COUNT, col_data);
      end
      pixels      = cur_rows * cur_cols;
      total       = pixels + cur_cols + 1;
      restart_due = ($urandom_range(7) == 0);
      len         = restart_due ? $urandom_range(1, total - 1) : total;
      extremes    = ($urandom_range(3) == 0);
      for (int i = 0; i < len; i++) begin
        // Idling pattern moves through three stages over the random part.
        if (words_sent - start < RANDOM_WORDS / 3) begin
          send_idle = 11;
          recv_idle = 60;
        end else if (words_sent - start < 2 * RANDOM_WORDS / 3) begin
          send_idle = 60;
          recv_idle = 11;
        end else begin
          send_idle = 0;
          recv_idle = 0;
        end
        if (i < pixels) begin
          op = ($urandom_range(99) < 3) ? hbs_pkg::OP_FLUSH : hbs_pkg::OP_SAMPLE;
        end else begin
          op = ($urandom_range(99) < 5) ? hbs_pkg::OP_SAMPLE : hbs_pkg::OP_FLUSH;
        end
        if (extremes) h = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        else h = hbs_pkg::sample_t'($urandom);
        send_word(op, h);
      end
    end

    // Let every expected word drain, then allow for stray late words.
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
